// File: src/rgbhsv_pkg.sv
// ============================================================================
// RGB to HSV converter package
// Shared widths, sector codes and pipeline payload types.
// ============================================================================
package rgbhsv_pkg;

    // Width of one colour component and of the fractional results.
    localparam int COMPONENT_BITS = 8;
    localparam int FRACTION_BITS  = 16;

    // The hue divisor is 6 * delta, which needs three bits above a component.
    localparam int DEN_BITS = COMPONENT_BITS + 3;

    // Which component holds the maximum.
    localparam int SECTOR_BITS = 2;
    localparam logic [SECTOR_BITS-1:0] SECTOR_RED   = 2'd0;
    localparam logic [SECTOR_BITS-1:0] SECTOR_GREEN = 2'd1;
    localparam logic [SECTOR_BITS-1:0] SECTOR_BLUE  = 2'd2;

    // Payload of the first front-end stage.
    typedef struct packed {
        logic [COMPONENT_BITS-1:0] red;
        logic [COMPONENT_BITS-1:0] green;
        logic [COMPONENT_BITS-1:0] blue;
        logic [COMPONENT_BITS-1:0] max_val;
        logic [COMPONENT_BITS-1:0] min_val;
        logic [SECTOR_BITS-1:0]    sector;
    } front_t;

    // Payload that travels through the divider stages.
    typedef struct packed {
        logic [DEN_BITS-1:0]       hue_rem;
        logic [DEN_BITS-1:0]       hue_den;
        logic [FRACTION_BITS-1:0]  hue_quo;
        logic [DEN_BITS-1:0]       sat_rem;
        logic [COMPONENT_BITS-1:0] sat_den;
        logic [FRACTION_BITS-1:0]  sat_quo;
        logic                      sat_full;
        logic                      grey;
        logic [COMPONENT_BITS-1:0] bright;
    } div_t;

endpackage

// File: src/rgbhsv_front.sv
// ============================================================================
// RGB to HSV front end
// Two register stages: maximum, minimum and sector, then delta, the hue
// numerator and divisor and the flags for the special cases.
// ============================================================================
module rgbhsv_front (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic [rgbhsv_pkg::COMPONENT_BITS-1:0]     red,
    input  logic [rgbhsv_pkg::COMPONENT_BITS-1:0]     green,
    input  logic [rgbhsv_pkg::COMPONENT_BITS-1:0]     blue,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output rgbhsv_pkg::div_t                          out_data
);

    rgbhsv_pkg::front_t a_reg, a_next;
    rgbhsv_pkg::div_t   b_reg, b_next;
    logic               a_valid_reg, b_valid_reg;
    logic               a_ready, b_ready;

    logic [rgbhsv_pkg::COMPONENT_BITS-1:0] delta;
    logic [rgbhsv_pkg::DEN_BITS-1:0]       delta_ext;
    logic [rgbhsv_pkg::DEN_BITS-1:0]       six_delta;
    logic [rgbhsv_pkg::DEN_BITS-1:0]       num;

    // A stage takes a new transaction when it is empty or its content moves on.
    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = a_ready;

    // Stage A: maximum and minimum, and the sector with red tested first.
    always_comb
    begin
        a_next.red     = red;
        a_next.green   = green;
        a_next.blue    = blue;
        a_next.max_val = red;
        if (green > a_next.max_val)
        begin
            a_next.max_val = green;
        end
        if (blue > a_next.max_val)
        begin
            a_next.max_val = blue;
        end
        a_next.min_val = red;
        if (green < a_next.min_val)
        begin
            a_next.min_val = green;
        end
        if (blue < a_next.min_val)
        begin
            a_next.min_val = blue;
        end
        if (red == a_next.max_val)
        begin
            a_next.sector = rgbhsv_pkg::SECTOR_RED;
        end
        else if (green == a_next.max_val)
        begin
            a_next.sector = rgbhsv_pkg::SECTOR_GREEN;
        end
        else
        begin
            a_next.sector = rgbhsv_pkg::SECTOR_BLUE;
        end
    end

    // Stage B: delta, hue numerator and divisor, and the division seeds.
    // The numerator lies in [0, 6 * delta) for a non-grey pixel, so modular arithmetic at
    // divisor width gives the exact value.
    always_comb
    begin
        delta     = a_reg.max_val - a_reg.min_val;
        delta_ext = rgbhsv_pkg::DEN_BITS'(delta);
        six_delta = (delta_ext << 2) + (delta_ext << 1);
        case (a_reg.sector)
            rgbhsv_pkg::SECTOR_RED:
            begin
                if (a_reg.green >= a_reg.blue)
                begin
                    num = rgbhsv_pkg::DEN_BITS'(a_reg.green)
                        - rgbhsv_pkg::DEN_BITS'(a_reg.blue);
                end
                else
                begin
                    num = six_delta - (rgbhsv_pkg::DEN_BITS'(a_reg.blue)
                        - rgbhsv_pkg::DEN_BITS'(a_reg.green));
                end
            end
            rgbhsv_pkg::SECTOR_GREEN:
            begin
                num = (delta_ext << 1) + rgbhsv_pkg::DEN_BITS'(a_reg.blue)
                    - rgbhsv_pkg::DEN_BITS'(a_reg.red);
            end
            rgbhsv_pkg::SECTOR_BLUE:
            begin
                num = (delta_ext << 2) + rgbhsv_pkg::DEN_BITS'(a_reg.red)
                    - rgbhsv_pkg::DEN_BITS'(a_reg.green);
            end
            default:
            begin
                num = '0;
            end
        endcase

        b_next.hue_rem  = num;
        b_next.hue_den  = six_delta;
        b_next.hue_quo  = '0;
        b_next.sat_rem  = delta_ext;
        b_next.sat_den  = a_reg.max_val;
        b_next.sat_quo  = '0;
        // A zero minimum means delta equals max: the quotient is one whole.
        b_next.sat_full = (a_reg.min_val == '0);
        b_next.grey     = (delta == '0);
        b_next.bright   = a_reg.max_val;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_reg <= a_next;
        end
        if (a_valid_reg && b_ready)
        begin
            b_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_reg;

endmodule

// File: src/rgbhsv_div_stage.sv
// ============================================================================
// RGB to HSV divider stage
// One restoring step of both fraction divisions: one quotient bit each.
// ============================================================================
module rgbhsv_div_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rgbhsv_pkg::div_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rgbhsv_pkg::div_t out_data
);

    rgbhsv_pkg::div_t data_reg, data_next;
    logic             valid_reg;

    logic [rgbhsv_pkg::DEN_BITS:0] hue_shift, hue_den_ext;
    logic [rgbhsv_pkg::DEN_BITS:0] sat_shift, sat_den_ext;
    logic                          hue_bit, sat_bit;

    assign in_ready = !valid_reg || out_ready;

    // Double the remainder, subtract the divisor where it fits.
    always_comb
    begin
        data_next   = in_data;
        hue_shift   = {in_data.hue_rem, 1'b0};
        hue_den_ext = (rgbhsv_pkg::DEN_BITS+1)'(in_data.hue_den);
        sat_shift   = {in_data.sat_rem, 1'b0};
        sat_den_ext = (rgbhsv_pkg::DEN_BITS+1)'(in_data.sat_den);
        hue_bit     = (hue_shift >= hue_den_ext);
        sat_bit     = (sat_shift >= sat_den_ext);
        if (hue_bit)
        begin
            data_next.hue_rem = rgbhsv_pkg::DEN_BITS'(hue_shift - hue_den_ext);
        end
        else
        begin
            data_next.hue_rem = rgbhsv_pkg::DEN_BITS'(hue_shift);
        end
        if (sat_bit)
        begin
            data_next.sat_rem = rgbhsv_pkg::DEN_BITS'(sat_shift - sat_den_ext);
        end
        else
        begin
            data_next.sat_rem = rgbhsv_pkg::DEN_BITS'(sat_shift);
        end
        data_next.hue_quo = {in_data.hue_quo[rgbhsv_pkg::FRACTION_BITS-2:0], hue_bit};
        data_next.sat_quo = {in_data.sat_quo[rgbhsv_pkg::FRACTION_BITS-2:0], sat_bit};
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: src/rgb_to_hsv_pixel_converter.sv
// Path: an accepted transaction passes the front-end registers, then the
// divider stages, one quotient bit per stage, on the way to its result.
// Throughput: one pixel per cycle while the output is not stalled; every
// stage moves on when its successor has room, so stalled data is not lost.
// Reset: rst_n clears all valid bits asynchronously; payloads are not reset.
// ============================================================================
// RGB to HSV pixel converter
// Hexcone conversion of one pixel per transaction: brightness, saturation
// and hue, with both fraction divisions in a bit-per-stage pipeline.
// ============================================================================
module rgb_to_hsv_pixel_converter (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [rgbhsv_pkg::COMPONENT_BITS-1:0] red,
    input  logic [rgbhsv_pkg::COMPONENT_BITS-1:0] green,
    input  logic [rgbhsv_pkg::COMPONENT_BITS-1:0] blue,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [rgbhsv_pkg::FRACTION_BITS-1:0]  hue,
    output logic [rgbhsv_pkg::FRACTION_BITS-1:0]  saturation,
    output logic [rgbhsv_pkg::COMPONENT_BITS-1:0] brightness
);

    rgbhsv_pkg::div_t chain_data  [0:rgbhsv_pkg::FRACTION_BITS];
    logic             chain_valid [0:rgbhsv_pkg::FRACTION_BITS];
    logic             chain_ready [0:rgbhsv_pkg::FRACTION_BITS];

    // Front end: extremes, sector and division seeds.
    rgbhsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    // Divider pipeline: one stage per fraction bit.
    for (genvar i = 0; i < rgbhsv_pkg::FRACTION_BITS; i++)
    begin : g_div
        rgbhsv_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    assign chain_ready[rgbhsv_pkg::FRACTION_BITS] = out_ready;
    assign out_valid = chain_valid[rgbhsv_pkg::FRACTION_BITS];

    // Result selection: grey pixels give zero hue and saturation, and a pure
    // hue saturates at the largest code.
    always_comb
    begin
        brightness = chain_data[rgbhsv_pkg::FRACTION_BITS].bright;
        if (chain_data[rgbhsv_pkg::FRACTION_BITS].grey)
        begin
            hue        = '0;
            saturation = '0;
        end
        else
        begin
            hue = chain_data[rgbhsv_pkg::FRACTION_BITS].hue_quo;
            if (chain_data[rgbhsv_pkg::FRACTION_BITS].sat_full)
            begin
                saturation = '1;
            end
            else
            begin
                saturation = chain_data[rgbhsv_pkg::FRACTION_BITS].sat_quo;
            end
        end
    end

endmodule

// File: tb/rgb_to_hsv_pixel_converter_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// RGB to HSV pixel converter testbench
// Streams pixels through the converter with random gaps on the input side
// and random back-pressure on the output side, including one long output
// hold-off that fills the pipeline. Every result is compared field by field
// with a hexcone prediction computed when the pixel transaction is taken.
// ============================================================================
module rgb_to_hsv_pixel_converter_tb;

    localparam int COMPONENT_BITS = rgbhsv_pkg::COMPONENT_BITS;
    localparam int FRACTION_BITS  = rgbhsv_pkg::FRACTION_BITS;
    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 7;
    localparam int PIPE_DEPTH    = 2 + FRACTION_BITS;
    localparam int TAIL_CYCLES   = PIPE_DEPTH + 20;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_CODE      = (1 << COMPONENT_BITS) - 1;

    typedef struct packed {
        logic [COMPONENT_BITS-1:0] red;
        logic [COMPONENT_BITS-1:0] green;
        logic [COMPONENT_BITS-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [FRACTION_BITS-1:0]  hue;
        logic [FRACTION_BITS-1:0]  saturation;
        logic [COMPONENT_BITS-1:0] brightness;
    } hsv_t;

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      in_valid   = 1'b0;
    logic                      in_ready;
    logic [COMPONENT_BITS-1:0] red        = '0;
    logic [COMPONENT_BITS-1:0] green      = '0;
    logic [COMPONENT_BITS-1:0] blue       = '0;
    logic                      out_valid;
    logic                      out_ready  = 1'b0;
    logic [FRACTION_BITS-1:0]  hue;
    logic [FRACTION_BITS-1:0]  saturation;
    logic [COMPONENT_BITS-1:0] brightness;

    pixel_t pixel_backlog[$];
    hsv_t   hsv_pending[$];
    pixel_t next_px;
    hsv_t   want;

    int issued_cnt     = 0;
    int accepted_cnt   = 0;
    int results_cnt    = 0;
    int results_seen   = 0;
    int mismatch_cnt   = 0;
    int idle_cycles    = 0;
    int send_gap       = 0;
    int ready_gap      = 0;
    int hold_left      = 0;
    int hold_requests  = 0;
    int holds_started  = 0;
    int gap_max        = 0;
    int stall_max      = 0;

    rgb_to_hsv_pixel_converter u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    // Free-running clock.
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Hexcone conversion of one pixel, with exact integer compares.
    function automatic hsv_t hexcone_of(pixel_t px);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned hi;
        int unsigned lo;
        int unsigned delta;
        int unsigned num;
        int unsigned sat;
        hsv_t        res;
        r  = 32'(px.red);
        g  = 32'(px.green);
        b  = 32'(px.blue);
        hi = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        lo = r;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        delta = hi - lo;
        res   = '0;
        res.brightness = hi[COMPONENT_BITS-1:0];
        if (delta != 0)
        begin
            sat = (delta << FRACTION_BITS) / hi;
            if (sat > (1 << FRACTION_BITS) - 1)
                sat = (1 << FRACTION_BITS) - 1;
            res.saturation = sat[FRACTION_BITS-1:0];
            // Sector rule: red wins a tie, then green, then blue.
            if (r == hi)
                num = (g >= b) ? g - b : 6 * delta - (b - g);
            else if (g == hi)
                num = 2 * delta + b - r;
            else
                num = 4 * delta + r - g;
            num = (num << FRACTION_BITS) / (6 * delta);
            res.hue = num[FRACTION_BITS-1:0];
        end
        return res;
    endfunction

    // Random pixel, biased towards ties, greys, pure hues and near-greys.
    function automatic pixel_t random_pixel();
        pixel_t      px;
        int unsigned v;
        int unsigned base;
        px.red   = COMPONENT_BITS'($urandom_range(0, MAX_CODE));
        px.green = COMPONENT_BITS'($urandom_range(0, MAX_CODE));
        px.blue  = COMPONENT_BITS'($urandom_range(0, MAX_CODE));
        v        = $urandom_range(0, MAX_CODE);
        case ($urandom_range(0, 9))
            5:
            begin
                // Two components tie for the maximum or the minimum.
                case ($urandom_range(0, 2))
                    0: begin px.red = COMPONENT_BITS'(v); px.green = COMPONENT_BITS'(v); end
                    1: begin px.green = COMPONENT_BITS'(v); px.blue = COMPONENT_BITS'(v); end
                    default: begin px.red = COMPONENT_BITS'(v); px.blue = COMPONENT_BITS'(v); end
                endcase
            end
            6:
            begin
                px.red   = COMPONENT_BITS'(v);
                px.green = COMPONENT_BITS'(v);
                px.blue  = COMPONENT_BITS'(v);
            end
            7:
            begin
                case ($urandom_range(0, 2))
                    0: px.red = '0;
                    1: px.green = '0;
                    default: px.blue = '0;
                endcase
            end
            8:
            begin
                base     = $urandom_range(0, MAX_CODE - 5);
                px.red   = COMPONENT_BITS'(base + $urandom_range(0, 5));
                px.green = COMPONENT_BITS'(base + $urandom_range(0, 5));
                px.blue  = COMPONENT_BITS'(base + $urandom_range(0, 5));
            end
            9:
            begin
                px.red   = $urandom_range(0, 1) ? '1 : '0;
                px.green = $urandom_range(0, 1) ? '1 : '0;
                px.blue  = $urandom_range(0, 1) ? '1 : '0;
            end
            default:
            begin
            end
        endcase
        return px;
    endfunction

    // Sender: presents pixels from the backlog, with a random gap after each.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && accepted_cnt != issued_cnt)
            begin
                // Current transaction still waiting; hold it steady.
            end
            else if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pixel_backlog.size() > 0)
            begin
                next_px    = pixel_backlog.pop_front();
                red       <= next_px.red;
                green     <= next_px.green;
                blue      <= next_px.blue;
                in_valid  <= 1'b1;
                issued_cnt = issued_cnt + 1;
                send_gap   = $urandom_range(0, gap_max);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls per result, plus the requested long hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_requests != holds_started)
            begin
                holds_started = holds_started + 1;
                hold_left     = LONG_HOLD;
            end
            if (results_cnt != results_seen)
            begin
                results_seen = results_cnt;
                ready_gap    = $urandom_range(0, stall_max);
            end
            if (hold_left > 0)
            begin
                hold_left  = hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (ready_gap > 0)
            begin
                ready_gap  = ready_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on each input transaction, checks each output one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles = idle_cycles + 1;
            if (in_valid && in_ready)
            begin
                hsv_pending.push_back(hexcone_of({red, green, blue}));
                accepted_cnt = accepted_cnt + 1;
                idle_cycles  = 0;
            end
            if (out_valid && out_ready)
            begin
                idle_cycles = 0;
                results_cnt = results_cnt + 1;
                if (hsv_pending.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual hue %0d sat %0d val %0d",
                             $time, hue, saturation, brightness);
                    mismatch_cnt = mismatch_cnt + 1;
                end
                else
                begin
                    want = hsv_pending.pop_front();
                    if (hue !== want.hue)
                    begin
                        $display("%0t: hue mismatch, expected %0d, actual %0d",
                                 $time, want.hue, hue);
                        mismatch_cnt = mismatch_cnt + 1;
                    end
                    if (saturation !== want.saturation)
                    begin
                        $display("%0t: saturation mismatch, expected %0d, actual %0d",
                                 $time, want.saturation, saturation);
                        mismatch_cnt = mismatch_cnt + 1;
                    end
                    if (brightness !== want.brightness)
                    begin
                        $display("%0t: brightness mismatch, expected %0d, actual %0d",
                                 $time, want.brightness, brightness);
                        mismatch_cnt = mismatch_cnt + 1;
                    end
                end
            end
            // Watchdog on a stream that has stopped moving.
            if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_MAX);
                $display("rgb_to_hsv_pixel_converter_tb: done, errors");
                $finish;
            end
        end
    end

    // Waits until every queued pixel has been taken and every result seen.
    task automatic drain_stream();
        while (pixel_backlog.size() != 0 || accepted_cnt != issued_cnt)
            @(posedge clk);
        while (hsv_pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            pixel_backlog.push_back(random_pixel());
    endtask

    // Test sequence.
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed pixels: greys, pure hues, ties and sector boundaries.
        gap_max   = 0;
        stall_max = 0;
        pixel_backlog.push_back('{8'd0,   8'd0,   8'd0});
        pixel_backlog.push_back('{8'd255, 8'd255, 8'd255});
        pixel_backlog.push_back('{8'd128, 8'd128, 8'd128});
        pixel_backlog.push_back('{8'd255, 8'd0,   8'd0});
        pixel_backlog.push_back('{8'd0,   8'd255, 8'd0});
        pixel_backlog.push_back('{8'd0,   8'd0,   8'd255});
        pixel_backlog.push_back('{8'd255, 8'd255, 8'd0});
        pixel_backlog.push_back('{8'd0,   8'd255, 8'd255});
        pixel_backlog.push_back('{8'd255, 8'd0,   8'd255});
        pixel_backlog.push_back('{8'd255, 8'd0,   8'd1});
        pixel_backlog.push_back('{8'd1,   8'd0,   8'd0});
        pixel_backlog.push_back('{8'd0,   8'd0,   8'd1});
        pixel_backlog.push_back('{8'd1,   8'd1,   8'd0});
        pixel_backlog.push_back('{8'd255, 8'd254, 8'd254});
        pixel_backlog.push_back('{8'd254, 8'd255, 8'd255});
        pixel_backlog.push_back('{8'd255, 8'd255, 8'd254});
        pixel_backlog.push_back('{8'd128, 8'd64,  8'd200});
        pixel_backlog.push_back('{8'd200, 8'd128, 8'd64});
        pixel_backlog.push_back('{8'd64,  8'd200, 8'd128});
        pixel_backlog.push_back('{8'd170, 8'd85,  8'd255});
        pixel_backlog.push_back('{8'd1,   8'd255, 8'd0});
        pixel_backlog.push_back('{8'd255, 8'd1,   8'd255});
        drain_stream();

        // Random gaps and stalls on both sides.
        gap_max   = 6;
        stall_max = 6;
        queue_random(600);
        drain_stream();

        // Long output hold-off while the sender keeps offering pixels.
        gap_max       = 0;
        stall_max     = 0;
        hold_requests = hold_requests + 1;
        queue_random(300);
        drain_stream();

        // Full-rate input against a stalling output.
        gap_max   = 0;
        stall_max = 6;
        queue_random(500);
        drain_stream();

        // Sparse input into an always-ready output.
        gap_max   = 6;
        stall_max = 0;
        queue_random(500);
        drain_stream();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && hsv_pending.size() == 0)
            $display("rgb_to_hsv_pixel_converter_tb: done, clean");
        else
            $display("rgb_to_hsv_pixel_converter_tb: done, errors");
        $finish;
    end

endmodule
